FILE: rtl/rmsc_pkg.sv
// ----------------------------------------------------------------------------
// rmsc_pkg
// Shared types and constants of the RGB matrix scan controller: command
// codes, register indexes, color phases and the bundles between its units.
// ----------------------------------------------------------------------------
package rmsc_pkg;

    // Command codes of the input channel
    localparam logic [1:0] CMD_SET_PIXEL = 2'd0;
    localparam logic [1:0] CMD_CLEAR     = 2'd1;
    localparam logic [1:0] CMD_RENDER    = 2'd2;

    // Register indexes (word address on the APB port)
    localparam logic [1:0] REG_RED_TIME   = 2'd0;
    localparam logic [1:0] REG_GREEN_TIME = 2'd1;
    localparam logic [1:0] REG_BLUE_TIME  = 2'd2;

    // Register reset values
    localparam logic [15:0] RED_TIME_RST   = 16'd100;
    localparam logic [15:0] GREEN_TIME_RST = 16'd70;
    localparam logic [15:0] BLUE_TIME_RST  = 16'd60;

    // Color phases of one row, in scan order
    localparam logic [1:0] PH_RED   = 2'd0;
    localparam logic [1:0] PH_BLUE  = 2'd1;
    localparam logic [1:0] PH_GREEN = 2'd2;

    // Frame geometry and active-low values
    localparam int          APB_AW    = 4;
    localparam logic [2:0]  ROW_LAST  = 3'd7;
    localparam logic [7:0]  OFF_BYTE  = 8'hFF;
    localparam logic [23:0] ROW_OFF   = 24'hFF_FFFF;

    // Dwell times from the register file
    typedef struct packed {
        logic [15:0] red_time;
        logic [15:0] green_time;
        logic [15:0] blue_time;
    } t_cfg;

    // Access bundle from the sequencer to the frame store
    typedef struct packed {
        logic        rd_en;
        logic [2:0]  rd_row;
        logic        wr_en;
        logic [2:0]  wr_row;
        logic [23:0] wr_data;
        logic        clear;
    } t_fs_req;

    // One scan word
    typedef struct packed {
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [7:0]  third_byte;
        logic [7:0]  row_select;
        logic [15:0] dwell_time;
        logic        last_of_frame;
    } t_scan_word;

endpackage

FILE: rtl/rmsc_cmd_if.sv
// ----------------------------------------------------------------------------
// rmsc_cmd_if
// Command channel: valid/ready handshake with one command beat.
// ----------------------------------------------------------------------------
interface rmsc_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [2:0] column;
    logic [2:0] row;
    logic       red_on;
    logic       green_on;
    logic       blue_on;

    modport source (
        output valid, command, column, row, red_on, green_on, blue_on,
        input  ready
    );
    modport sink (
        input  valid, command, column, row, red_on, green_on, blue_on,
        output ready
    );
endinterface

FILE: rtl/rmsc_scan_if.sv
// ----------------------------------------------------------------------------
// rmsc_scan_if
// Scan word channel: valid/ready handshake with one scan word per beat.
// ----------------------------------------------------------------------------
interface rmsc_scan_if;
    logic        valid;
    logic        ready;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [7:0]  third_byte;
    logic [7:0]  row_select;
    logic [15:0] dwell_time;
    logic        last_of_frame;

    modport source (
        output valid, first_byte, second_byte, third_byte, row_select,
               dwell_time, last_of_frame,
        input  ready
    );
    modport sink (
        input  valid, first_byte, second_byte, third_byte, row_select,
               dwell_time, last_of_frame,
        output ready
    );
endinterface

FILE: rtl/rmsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// rmsc_cfg_regs
// APB register file holding the red, green and blue dwell times.
// ----------------------------------------------------------------------------
module rmsc_cfg_regs
    import rmsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [15:0] r_red_time;
    logic [15:0] r_green_time;
    logic [15:0] r_blue_time;
    logic        wr_acc;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_acc  = psel && penable && pwrite;

    // Write the addressed register in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_time   <= RED_TIME_RST;
            r_green_time <= GREEN_TIME_RST;
            r_blue_time  <= BLUE_TIME_RST;
        end else if (wr_acc) begin
            case (reg_idx)
                REG_RED_TIME:   r_red_time   <= pwdata[15:0];
                REG_GREEN_TIME: r_green_time <= pwdata[15:0];
                REG_BLUE_TIME:  r_blue_time  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register on a read
    always_comb begin
        case (reg_idx)
            REG_RED_TIME:   prdata = {16'd0, r_red_time};
            REG_GREEN_TIME: prdata = {16'd0, r_green_time};
            REG_BLUE_TIME:  prdata = {16'd0, r_blue_time};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_cfg.red_time   = r_red_time;
    assign o_cfg.green_time = r_green_time;
    assign o_cfg.blue_time  = r_blue_time;

endmodule

FILE: rtl/rmsc_frame_store.sv
// ----------------------------------------------------------------------------
// rmsc_frame_store
// Eight-row frame memory with a registered read. A row that was not
// written since reset or the last clear reads as all ones (every LED off).
// ----------------------------------------------------------------------------
module rmsc_frame_store
    import rmsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_fs_req     i_req,
    output logic [23:0] o_rd_data
);

    logic [23:0] r_mem [8];
    logic [7:0]  r_row_vld;
    logic [23:0] r_rd_data;
    logic        r_rd_vld;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_row] <= i_req.wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_row];
        end
    end

    // Track written rows; clear drops them all at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= 8'd0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_row_vld <= 8'd0;
            end else if (i_req.wr_en) begin
                r_row_vld[i_req.wr_row] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_row_vld[i_req.rd_row];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : ROW_OFF;

endmodule

FILE: rtl/rmsc_scan_seq.sv
// ----------------------------------------------------------------------------
// rmsc_scan_seq
// Command sequencer: read-modify-write for set pixel, clear, and the row and
// color walk of a render into a registered scan word output.
// ----------------------------------------------------------------------------
module rmsc_scan_seq
    import rmsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    rmsc_cmd_if.sink           i_cmd,
    rmsc_scan_if.source        o_scan,
    input  t_cfg               i_cfg,
    input  logic [23:0]        i_rd_data,
    output t_fs_req            o_fs_req
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SET  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [2:0]  r_row, n_row;
    logic [1:0]  r_phase, n_phase;
    logic [2:0]  r_col, n_col;
    logic        r_red, n_red;
    logic        r_green, n_green;
    logic        r_blue, n_blue;
    logic        r_out_vld, n_out_vld;
    t_scan_word  r_out, n_out;

    logic        cmd_acc;
    logic        out_free;
    logic [23:0] set_word;
    t_scan_word  word;

    assign cmd_acc  = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_out_vld || o_scan.ready;

    // Merge the pixel's three color bits into the row read back
    always_comb begin
        set_word                  = i_rd_data;
        set_word[{2'b10, r_col}]  = !r_red;
        set_word[{2'b01, r_col}]  = !r_green;
        set_word[{2'b00, r_col}]  = !r_blue;
    end

    // Build the scan word of the current row and phase
    always_comb begin
        word.first_byte    = OFF_BYTE;
        word.second_byte   = OFF_BYTE;
        word.third_byte    = OFF_BYTE;
        word.row_select    = 8'd1 << r_row;
        word.last_of_frame = 1'b0;
        case (r_phase)
            PH_RED: begin
                word.first_byte = i_rd_data[23:16];
                word.dwell_time = i_cfg.red_time;
            end
            PH_BLUE: begin
                word.second_byte = i_rd_data[7:0];
                word.dwell_time  = i_cfg.blue_time;
            end
            PH_GREEN: begin
                word.third_byte    = i_rd_data[15:8];
                word.dwell_time    = i_cfg.green_time;
                word.last_of_frame = (r_row == ROW_LAST);
            end
            default: begin
                word.dwell_time = i_cfg.red_time;
            end
        endcase
    end

    // Next-state logic
    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_phase   = r_phase;
        n_col     = r_col;
        n_red     = r_red;
        n_green   = r_green;
        n_blue    = r_blue;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        o_fs_req  = '0;

        // Drop the output beat once taken
        if (r_out_vld && o_scan.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (cmd_acc) begin
                    case (i_cmd.command)
                        CMD_SET_PIXEL: begin
                            o_fs_req.rd_en  = 1'b1;
                            o_fs_req.rd_row = i_cmd.row;
                            n_row   = i_cmd.row;
                            n_col   = i_cmd.column;
                            n_red   = i_cmd.red_on;
                            n_green = i_cmd.green_on;
                            n_blue  = i_cmd.blue_on;
                            n_state = ST_SET;
                        end
                        CMD_CLEAR: begin
                            o_fs_req.clear = 1'b1;
                        end
                        CMD_RENDER: begin
                            o_fs_req.rd_en  = 1'b1;
                            o_fs_req.rd_row = 3'd0;
                            n_row   = 3'd0;
                            n_phase = PH_RED;
                            n_state = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SET: begin
                o_fs_req.wr_en   = 1'b1;
                o_fs_req.wr_row  = r_row;
                o_fs_req.wr_data = set_word;
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = word;
                    case (r_phase)
                        PH_RED:  n_phase = PH_BLUE;
                        PH_BLUE: n_phase = PH_GREEN;
                        default: begin
                            // Row done: fetch the next one or finish
                            if (r_row == ROW_LAST) begin
                                n_state = ST_IDLE;
                            end else begin
                                o_fs_req.rd_en  = 1'b1;
                                o_fs_req.rd_row = r_row + 3'd1;
                                n_row   = r_row + 3'd1;
                                n_phase = PH_RED;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_phase <= n_phase;
        r_col   <= n_col;
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        r_out   <= n_out;
    end

    assign i_cmd.ready          = (r_state == ST_IDLE);
    assign o_scan.valid         = r_out_vld;
    assign o_scan.first_byte    = r_out.first_byte;
    assign o_scan.second_byte   = r_out.second_byte;
    assign o_scan.third_byte    = r_out.third_byte;
    assign o_scan.row_select    = r_out.row_select;
    assign o_scan.dwell_time    = r_out.dwell_time;
    assign o_scan.last_of_frame = r_out.last_of_frame;

endmodule

FILE: rtl/rgb_matrix_scan_controller.sv
// ----------------------------------------------------------------------------
// rgb_matrix_scan_controller
// Frame store and scan word generator for an 8x8 RGB LED matrix.
// ----------------------------------------------------------------------------
// Commands arrive on i_cmd (valid/ready): set pixel, clear frame, render.
// A render produces 24 scan words on o_scan (valid/ready), per row red, blue,
// green, each with the plane byte, a one-hot row select and its dwell time;
// the 24th word has last_of_frame set. Dwell times live in three APB
// registers at byte addresses 0, 4 and 8.
// Per command: clear marks every row unwritten at once, set pixel reads then
// writes the frame memory row, and render fetches row 0, then gives one word
// per cycle while o_scan does not stall (one memory read per row feeds its
// three words) through the frame memory read register and output register.
// One command is worked at a time; i_cmd.ready is high while idle, also
// while the last scan word still waits in the output register.
// A stall on o_scan holds the output word and pauses the row walk.
// Reset turns every LED off (no clearing pass is needed) and loads the dwell
// times 100, 70 and 60.
// ----------------------------------------------------------------------------
module rgb_matrix_scan_controller
    import rmsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    rmsc_cmd_if.sink          i_cmd,
    rmsc_scan_if.source       o_scan,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg        cfg;
    t_fs_req     fs_req;
    logic [23:0] fs_rd_data;

    // Dwell time registers
    rmsc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Frame memory
    rmsc_frame_store u_frame_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (fs_req),
        .o_rd_data (fs_rd_data)
    );

    // Command sequencer and output register
    rmsc_scan_seq u_scan_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_scan    (o_scan),
        .i_cfg     (cfg),
        .i_rd_data (fs_rd_data),
        .o_fs_req  (fs_req)
    );

endmodule

FILE: tb/sv/tb_rgb_matrix_scan_controller.sv
// ----------------------------------------------------------------------------
// tb_rgb_matrix_scan_controller
// Self-checking bench for the 8x8 RGB matrix scan controller. A shadow frame
// store and dwell register set predict every scan word of each render beat.
// Directed tests cover reset state, register extremes, corner pixels, the
// unused command code and a long output stall. A randomized run then mixes
// pixel writes, clears and renders under random valid/ready gaps.
// ----------------------------------------------------------------------------
module tb_rgb_matrix_scan_controller;
    import rmsc_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [1:0] REG_SPARE   = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         SETTLE      = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rmsc_cmd_if  cmd_bus ();
    rmsc_scan_if scan_bus ();

    rgb_matrix_scan_controller uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_scan  (scan_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow state of the block
    logic [23:0] shadow_rows [8];
    logic [15:0] red_dwell;
    logic [15:0] green_dwell;
    logic [15:0] blue_dwell;
    t_scan_word  scan_words_due [$];

    // Run control and statistics
    int err_count     = 0;
    int words_checked = 0;
    int n_set         = 0;
    int n_clear       = 0;
    int n_render      = 0;
    int n_unused      = 0;
    int n_reg_writes  = 0;
    bit src_quiet     = 0;
    bit snk_quiet     = 0;
    bit hold_req      = 0;
    int holds_done    = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Idle length: mostly zero or short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Update the shadow frame store and queue the scan words of a render
    function void apply_command(logic [1:0] cmd, logic [2:0] col, logic [2:0] row,
                                logic r_on, logic g_on, logic b_on);
        t_scan_word w;
        logic [23:0] line;
        case (cmd)
            CMD_SET_PIXEL: begin
                shadow_rows[row][16 + col] = ~r_on;
                shadow_rows[row][8 + col]  = ~g_on;
                shadow_rows[row][col]      = ~b_on;
            end
            CMD_CLEAR: begin
                for (int i = 0; i < 8; i++) shadow_rows[i] = ROW_OFF;
            end
            CMD_RENDER: begin
                for (int i = 0; i < 8; i++) begin
                    line            = shadow_rows[i];
                    w.row_select    = 8'(1 << i);
                    w.last_of_frame = 1'b0;
                    // red word
                    w.first_byte    = line[23:16];
                    w.second_byte   = OFF_BYTE;
                    w.third_byte    = OFF_BYTE;
                    w.dwell_time    = red_dwell;
                    scan_words_due.push_back(w);
                    // blue word
                    w.first_byte    = OFF_BYTE;
                    w.second_byte   = line[7:0];
                    w.dwell_time    = blue_dwell;
                    scan_words_due.push_back(w);
                    // green word
                    w.second_byte   = OFF_BYTE;
                    w.third_byte    = line[15:8];
                    w.dwell_time    = green_dwell;
                    w.last_of_frame = (i == 7);
                    scan_words_due.push_back(w);
                end
            end
            default: ;
        endcase
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endfunction

    // Score each scan beat against the oldest expected word
    always @(posedge i_clk) begin
        t_scan_word want;
        if (i_rst_n && scan_bus.valid && scan_bus.ready) begin
            if (scan_words_due.size() == 0) begin
                $error("unexpected scan word: row_select %0h", scan_bus.row_select);
                err_count++;
            end else begin
                want = scan_words_due.pop_front();
                check_field("first_byte", 16'(want.first_byte),
                            16'(scan_bus.first_byte));
                check_field("second_byte", 16'(want.second_byte),
                            16'(scan_bus.second_byte));
                check_field("third_byte", 16'(want.third_byte),
                            16'(scan_bus.third_byte));
                check_field("row_select", 16'(want.row_select),
                            16'(scan_bus.row_select));
                check_field("dwell_time", want.dwell_time, scan_bus.dwell_time);
                check_field("last_of_frame", 16'(want.last_of_frame),
                            16'(scan_bus.last_of_frame));
                words_checked++;
            end
        end
    end

    // Drive scan ready: random gaps, quiet stretches and requested hold-offs
    initial begin
        forever begin
            if (hold_req) begin
                scan_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 0;
                holds_done++;
            end else if (snk_quiet || $urandom_range(0, 99) < 65) begin
                scan_bus.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                scan_bus.ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end
        end
    end

    // Offer one command beat and wait until it is taken
    task automatic issue_command(input logic [1:0] cmd, input logic [2:0] col,
                                 input logic [2:0] row, input logic r_on,
                                 input logic g_on, input logic b_on);
        int gap;
        gap = src_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.command  <= cmd;
        cmd_bus.column   <= col;
        cmd_bus.row      <= row;
        cmd_bus.red_on   <= r_on;
        cmd_bus.green_on <= g_on;
        cmd_bus.blue_on  <= b_on;
        do @(posedge i_clk); while (!cmd_bus.ready);
        apply_command(cmd, col, row, r_on, g_on, b_on);
        case (cmd)
            CMD_SET_PIXEL: n_set++;
            CMD_CLEAR:     n_clear++;
            CMD_RENDER:    n_render++;
            default:       n_unused++;
        endcase
    endtask

    task automatic issue_random(input logic [1:0] cmd);
        issue_command(cmd, 3'($urandom), 3'($urandom), 1'($urandom),
                      1'($urandom), 1'($urandom));
    endtask

    // Drop valid and wait until every expected word has come and the block idles
    task automatic drain();
        cmd_bus.valid <= 1'b0;
        while (scan_words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // APB write, setup then access phase
    task automatic reg_write(input logic [1:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_RED_TIME:   red_dwell   = value;
            REG_GREEN_TIME: green_dwell = value;
            REG_BLUE_TIME:  blue_dwell  = value;
            default: ;
        endcase
        n_reg_writes++;
    endtask

    // APB read, compare against the shadow register
    task automatic reg_check(input logic [1:0] idx, input logic [15:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("prdata", want, prdata[15:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_dwell(input logic [15:0] red, input logic [15:0] green,
                             input logic [15:0] blue);
        reg_write(REG_RED_TIME, red);
        reg_write(REG_GREEN_TIME, green);
        reg_write(REG_BLUE_TIME, blue);
        reg_check(REG_RED_TIME, red_dwell);
        reg_check(REG_GREEN_TIME, green_dwell);
        reg_check(REG_BLUE_TIME, blue_dwell);
    endtask

    // Render the blank frame with reset dwell times
    task automatic test_reset_scan();
        reg_check(REG_RED_TIME, red_dwell);
        reg_check(REG_GREEN_TIME, green_dwell);
        reg_check(REG_BLUE_TIME, blue_dwell);
        issue_random(CMD_RENDER);
        drain();
    endtask

    // Exercise register extremes and a write past the register list
    task automatic test_dwell_registers();
        set_dwell(16'h0000, 16'hFFFF, 16'h0000);
        reg_write(REG_SPARE, 16'h1234);
        issue_random(CMD_RENDER);
        drain();
        set_dwell(16'hFFFF, 16'h0000, 16'hFFFF);
        issue_random(CMD_RENDER);
        drain();
    endtask

    // Light the corner pixels, light and unlight an inner one, try the unused code, then clear
    task automatic test_pixel_writes();
        set_dwell(16'd100, 16'd70, 16'd60);
        issue_command(CMD_SET_PIXEL, 3'd0, 3'd0, 1'b1, 1'b1, 1'b1);
        issue_command(CMD_SET_PIXEL, 3'd7, 3'd7, 1'b1, 1'b0, 1'b0);
        issue_command(CMD_SET_PIXEL, 3'd7, 3'd0, 1'b0, 1'b1, 1'b0);
        issue_command(CMD_SET_PIXEL, 3'd0, 3'd7, 1'b0, 1'b0, 1'b1);
        issue_command(CMD_SET_PIXEL, 3'd4, 3'd3, 1'b1, 1'b1, 1'b1);
        issue_command(CMD_SET_PIXEL, 3'd4, 3'd3, 1'b0, 1'b0, 1'b0);
        issue_random(CMD_RENDER);
        issue_command(CMD_UNUSED, 3'd7, 3'd7, 1'b1, 1'b1, 1'b1);
        issue_random(CMD_RENDER);
        issue_random(CMD_CLEAR);
        issue_random(CMD_RENDER);
        drain();
    endtask

    // Hold the scan side off while commands keep coming
    task automatic test_output_stall();
        src_quiet = 1;
        hold_req  = 1;
        issue_command(CMD_SET_PIXEL, 3'd2, 3'd5, 1'b1, 1'b0, 1'b1);
        issue_random(CMD_RENDER);
        issue_random(CMD_RENDER);
        issue_command(CMD_SET_PIXEL, 3'd6, 3'd1, 1'b0, 1'b1, 1'b1);
        issue_random(CMD_RENDER);
        drain();
        src_quiet = 0;
    endtask

    // Random command mix over several dwell settings
    task automatic test_random_traffic();
        int taken;
        int r;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_dwell(16'h0000, 16'h0000, 16'h0000);
                1: set_dwell(16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: set_dwell(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            taken = 0;
            while (taken < 58) begin
                // switch quiet stretches on and off now and then
                if (taken % 16 == 0) begin
                    src_quiet = ($urandom_range(0, 3) == 0);
                    snk_quiet = ($urandom_range(0, 3) == 0);
                end
                r = $urandom_range(0, 99);
                if (r < 72) begin
                    issue_random(CMD_SET_PIXEL);
                    taken++;
                end else if (r < 86) begin
                    issue_random(CMD_RENDER);
                    taken++;
                end else if (r < 94) begin
                    issue_random(CMD_CLEAR);
                    taken++;
                end else begin
                    issue_random(CMD_UNUSED);
                end
            end
            issue_random(CMD_RENDER);
            drain();
            src_quiet = 0;
            snk_quiet = 0;
        end
    endtask

    // Main sequence
    initial begin
        i_rst_n          <= 1'b0;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.command  <= CMD_SET_PIXEL;
        cmd_bus.column   <= 3'd0;
        cmd_bus.row      <= 3'd0;
        cmd_bus.red_on   <= 1'b0;
        cmd_bus.green_on <= 1'b0;
        cmd_bus.blue_on  <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        for (int i = 0; i < 8; i++) shadow_rows[i] = ROW_OFF;
        red_dwell   = RED_TIME_RST;
        green_dwell = GREEN_TIME_RST;
        blue_dwell  = BLUE_TIME_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_scan();
        test_dwell_registers();
        test_pixel_writes();
        test_output_stall();
        test_random_traffic();

        drain();
        repeat (30) @(posedge i_clk);
        $display("Covered %0d set-pixel, %0d clear, %0d render and %0d unused beats",
                 n_set, n_clear, n_render, n_unused);
        $display("Checked %0d scan words over %0d register writes, %0d output hold-offs",
                 words_checked, n_reg_writes, holds_done);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rmsc_pkg.sv
rtl/rmsc_cmd_if.sv
rtl/rmsc_scan_if.sv
rtl/rmsc_cfg_regs.sv
rtl/rmsc_frame_store.sv
rtl/rmsc_scan_seq.sv
rtl/rgb_matrix_scan_controller.sv
tb/sv/tb_rgb_matrix_scan_controller.sv
